[hdl/bti_pkg.sv]
// Package with the types, constants and codes shared by the table interpolator files.
package bti_pkg;

  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Y_POINTS = 64;
  localparam int IDX_W        = $clog2(MAX_X_POINTS);
  localparam int CNT_W        = 7;
  localparam int VAL_W        = 32;
  localparam int GRID_DEPTH   = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GRID_AW      = $clog2(GRID_DEPTH);
  localparam int W_W          = VAL_W + 1;
  localparam int OP_W         = VAL_W + 2;
  localparam int PROD_W       = 2 * OP_W;
  localparam int RS_W         = 2 * VAL_W + 2;
  localparam int ACC_W        = PROD_W + VAL_W;
  localparam int AREA_W       = 2 * VAL_W;
  localparam int QCNT_W       = $clog2(ACC_W + 1);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_X_BAD = 2'd1;
  localparam logic [1:0] STATUS_Y_BAD = 2'd2;

  localparam logic CFG_X_COUNT = 1'b0;
  localparam logic CFG_Y_COUNT = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD_X,
    MODE_LOAD_Y,
    MODE_LOAD_GRID,
    MODE_QUERY
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic [5:0]               col_index;
    logic [5:0]               row_index;
    logic signed [VAL_W-1:0]  load_value;
    logic signed [VAL_W-1:0]  coord_x;
    logic signed [VAL_W-1:0]  coord_y;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  result_value;
    logic                     x_below;
    logic                     x_above;
    logic                     y_below;
    logic                     y_above;
    logic                     saturated;
    logic [1:0]               table_status;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_PREV,
    ST_LD_NEXT,
    ST_LD_WRITE,
    ST_AX_FIRST,
    ST_AX_LAST,
    ST_AX_CHECK,
    ST_AX_MID,
    ST_AX_DOWN,
    ST_AX_UP,
    ST_AX_LO,
    ST_AX_HI,
    ST_AX_END,
    ST_GRID,
    ST_MAC,
    ST_DIV
  } state_t;

endpackage

[hdl/bilinear_table_interpolator.sv]
// Top level of the bilinear lookup-table interpolator.
//
// A command word is taken when start is high and busy is low. Mode load x and
// load y store one breakpoint and keep the block busy through ST_LD_PREV,
// ST_LD_NEXT and ST_LD_WRITE while the neighbor entries are read back to update
// the monotonic check. A grid load is written in the accept cycle and leaves
// the block free. A query hunts both axes from the intervals left by the
// previous query, reads the four corner values, forms the exact numerator and
// the cell area on one shared 34 by 34 multiplier, then divides on a
// bit-serial divider, which sets most of the busy time of a query. An axis
// whose coordinate lies strictly inside the table also hunts through ST_AX_MID
// and, if needed, ST_AX_DOWN or ST_AX_UP; one at or beyond a table end does
// not. A zero cell area skips the multiply and divide. One result word per
// query appears on rsp in the same cycle that busy falls, with rsp_strobe high
// for exactly one cycle; the receiver cannot stall.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes the x and y breakpoint counts.
// Reset clears the control state, the hunt indexes and the counts (to two);
// the breakpoint and grid memories are not cleared.
module bilinear_table_interpolator
  import bti_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  in_word_t         cmd,
  output logic             busy,
  output out_word_t        rsp,
  output logic             rsp_strobe,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  state_t state, state_next;
  in_word_t cmd_q;

  logic [CNT_W-1:0] x_count, y_count;
  logic [IDX_W-1:0] nx_m1, ny_m1, n_m1;

  logic ax;
  logic [IDX_W-1:0] p, hunt_x, hunt_y, h, hc, x_hi_idx, y_hi_idx, li, ax_raddr;
  logic bel, xb, xa, yb, ya;
  logic signed [VAL_W-1:0] x0v, x1v, y0v, y1v, x_rd, y_rd, t_rd, v, prev_v;
  logic lt, gt;

  logic [MAX_X_POINTS-1:0] bad_x;
  logic [MAX_Y_POINTS-1:0] bad_y;
  logic stat_x, stat_y;
  logic [1:0] stat_q;

  logic [2:0] gcnt;
  logic [GRID_AW-1:0] grid_raddr;
  logic [VAL_W-1:0] grid_rd;
  logic signed [VAL_W-1:0] g [4];

  logic signed [W_W-1:0] wx0, wx1, wy0, wy1, dx, dy;
  logic [3:0] mstep;
  logic signed [OP_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, prod_mag;
  logic signed [RS_W-1:0] rs;
  logic signed [ACC_W-1:0] acc, acc_mag;
  logic aneg, nneg, qneg;

  logic div_start, div_done;
  logic [ACC_W-1:0] quo;
  logic big_neg, big_pos;
  logic query_go;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign query_go  = start && !busy && (cmd.mode == MODE_QUERY);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= CNT_W'(2);
      y_count <= CNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_COUNT: x_count <= cfg_data;
        CFG_Y_COUNT: y_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective last index on each axis, with the counts held between two and the table size.
  always_comb begin
    if (x_count < CNT_W'(2)) nx_m1 = IDX_W'(1);
    else if (x_count > CNT_W'(MAX_X_POINTS)) nx_m1 = IDX_W'(MAX_X_POINTS - 1);
    else nx_m1 = IDX_W'(x_count - 1'b1);
    if (y_count < CNT_W'(2)) ny_m1 = IDX_W'(1);
    else if (y_count > CNT_W'(MAX_Y_POINTS)) ny_m1 = IDX_W'(MAX_Y_POINTS - 1);
    else ny_m1 = IDX_W'(y_count - 1'b1);
  end

  // Any out-of-order pair inside the used part of a table.
  always_comb begin
    stat_x = 1'b0;
    stat_y = 1'b0;
    for (int i = 1; i < MAX_X_POINTS; i++) begin
      if (IDX_W'(i) <= nx_m1) stat_x = stat_x | bad_x[i];
    end
    for (int i = 1; i < MAX_Y_POINTS; i++) begin
      if (IDX_W'(i) <= ny_m1) stat_y = stat_y | bad_y[i];
    end
  end

  // Axis selection shared by the load and hunt sequences.
  assign t_rd = ax ? y_rd : x_rd;
  assign v    = ax ? cmd_q.coord_y : cmd_q.coord_x;
  assign n_m1 = ax ? ny_m1 : nx_m1;
  assign h    = ax ? hunt_y : hunt_x;
  assign hc   = (h < IDX_W'(1)) ? IDX_W'(1) : ((h > n_m1) ? n_m1 : h);
  assign li   = ax ? cmd_q.row_index : cmd_q.col_index;
  assign lt   = v < t_rd;
  assign gt   = v > t_rd;

  bti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_X_POINTS)) u_x_ram (
    .clk   (clk),
    .we    ((state == ST_LD_WRITE) && !ax),
    .waddr (li),
    .wdata (cmd_q.load_value),
    .raddr (ax_raddr),
    .rdata (x_rd)
  );

  bti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_Y_POINTS)) u_y_ram (
    .clk   (clk),
    .we    ((state == ST_LD_WRITE) && ax),
    .waddr (li),
    .wdata (cmd_q.load_value),
    .raddr (ax_raddr),
    .rdata (y_rd)
  );

  bti_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (start && !busy && (cmd.mode == MODE_LOAD_GRID)),
    .waddr ({cmd.row_index, cmd.col_index}),
    .wdata (cmd.load_value),
    .raddr (grid_raddr),
    .rdata (grid_rd)
  );

  // Corner addresses in the order y0x0, y0x1, y1x0, y1x1.
  always_comb begin
    case (gcnt[1:0])
      2'd0:    grid_raddr = {y_hi_idx - 1'b1, x_hi_idx - 1'b1};
      2'd1:    grid_raddr = {y_hi_idx - 1'b1, x_hi_idx};
      2'd2:    grid_raddr = {y_hi_idx, x_hi_idx - 1'b1};
      default: grid_raddr = {y_hi_idx, x_hi_idx};
    endcase
  end

  // Sequencer: next state, breakpoint read address and divider start.
  always_comb begin
    state_next = state;
    ax_raddr   = p;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.mode)
            MODE_LOAD_X, MODE_LOAD_Y: state_next = ST_LD_PREV;
            MODE_QUERY:               state_next = ST_AX_FIRST;
            default:                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LD_PREV: begin
        ax_raddr   = li - 1'b1;
        state_next = ST_LD_NEXT;
      end
      ST_LD_NEXT: begin
        ax_raddr   = li + 1'b1;
        state_next = ST_LD_WRITE;
      end
      ST_LD_WRITE: state_next = ST_IDLE;
      ST_AX_FIRST: begin
        ax_raddr   = '0;
        state_next = ST_AX_LAST;
      end
      ST_AX_LAST: begin
        ax_raddr   = n_m1;
        state_next = ST_AX_CHECK;
      end
      ST_AX_CHECK: begin
        if (bel || !lt) begin
          state_next = ST_AX_LO;
        end else begin
          ax_raddr   = hc;
          state_next = ST_AX_MID;
        end
      end
      ST_AX_MID: begin
        if (lt && (p > IDX_W'(1))) begin
          ax_raddr   = p - 1'b1;
          state_next = ST_AX_DOWN;
        end else if (gt && (p < n_m1)) begin
          ax_raddr   = p + 1'b1;
          state_next = ST_AX_UP;
        end else begin
          state_next = ST_AX_LO;
        end
      end
      ST_AX_DOWN: begin
        if (lt && (p > IDX_W'(2))) begin
          ax_raddr = p - IDX_W'(2);
        end else begin
          state_next = ST_AX_LO;
        end
      end
      ST_AX_UP: begin
        if (gt && (p < n_m1)) begin
          ax_raddr = p + 1'b1;
        end else begin
          state_next = ST_AX_LO;
        end
      end
      ST_AX_LO: begin
        ax_raddr   = p - 1'b1;
        state_next = ST_AX_HI;
      end
      ST_AX_HI: begin
        ax_raddr   = p;
        state_next = ST_AX_END;
      end
      ST_AX_END: state_next = ax ? ST_GRID : ST_AX_FIRST;
      ST_GRID: begin
        if (gcnt == 3'd4) begin
          state_next = ((dx == '0) || (dy == '0)) ? ST_IDLE : ST_MAC;
        end
      end
      ST_MAC: begin
        if (mstep == 4'd13) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hunt_x     <= '0;
      hunt_y     <= '0;
      bad_x      <= '0;
      bad_y      <= '0;
      rsp_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      rsp_strobe <= 1'b0;
      if (state == ST_LD_WRITE) begin
        if (!ax) begin
          bad_x[li] <= (li != '0) && (prev_v >= cmd_q.load_value);
          if (li != IDX_W'(MAX_X_POINTS - 1)) begin
            bad_x[li + 1'b1] <= cmd_q.load_value >= x_rd;
          end
        end else begin
          bad_y[li] <= (li != '0) && (prev_v >= cmd_q.load_value);
          if (li != IDX_W'(MAX_Y_POINTS - 1)) begin
            bad_y[li + 1'b1] <= cmd_q.load_value >= y_rd;
          end
        end
      end
      if (state == ST_AX_LO) begin
        if (ax) hunt_y <= p;
        else hunt_x <= p;
      end
      if ((state == ST_GRID && gcnt == 3'd4 && ((dx == '0) || (dy == '0))) ||
          (state == ST_DIV && div_done)) begin
        rsp_strobe <= 1'b1;
      end
    end
  end

  // Saturation of the quotient magnitude to the signed 32-bit range.
  assign qneg    = nneg != aneg;
  assign big_neg = (|quo[ACC_W-1:VAL_W]) || (quo[VAL_W-1] && (|quo[VAL_W-2:0]));
  assign big_pos = |quo[ACC_W-1:VAL_W-1];

  // Operand selection for the shared multiplier.
  always_comb begin
    case (mstep)
      4'd0:    begin mul_a = OP_W'(g[0]); mul_b = OP_W'(wx0); end
      4'd1:    begin mul_a = OP_W'(g[1]); mul_b = OP_W'(wx1); end
      4'd3:    begin mul_a = $signed({2'b00, rs[VAL_W-1:0]}); mul_b = OP_W'(wy0); end
      4'd4:    begin mul_a = $signed(rs[RS_W-1:VAL_W]); mul_b = OP_W'(wy0); end
      4'd6:    begin mul_a = OP_W'(g[2]); mul_b = OP_W'(wx0); end
      4'd7:    begin mul_a = OP_W'(g[3]); mul_b = OP_W'(wx1); end
      4'd9:    begin mul_a = $signed({2'b00, rs[VAL_W-1:0]}); mul_b = OP_W'(wy1); end
      4'd10:   begin mul_a = $signed(rs[RS_W-1:VAL_W]); mul_b = OP_W'(wy1); end
      default: begin mul_a = OP_W'(dx); mul_b = OP_W'(dy); end
    endcase
  end

  assign prod_mag = prod[PROD_W-1] ? -prod : prod;
  assign acc_mag  = acc[ACC_W-1] ? -acc : acc;

  // Datapath registers of the load, hunt, corner and multiply phases.
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      cmd_q <= cmd;
      ax    <= (cmd.mode == MODE_LOAD_Y);
    end
    if (query_go) begin
      if (stat_x) stat_q <= STATUS_X_BAD;
      else if (stat_y) stat_q <= STATUS_Y_BAD;
      else stat_q <= STATUS_OK;
    end
    case (state)
      ST_LD_NEXT: prev_v <= t_rd;
      ST_AX_LAST: bel <= !gt;
      ST_AX_CHECK: begin
        if (ax) begin
          yb <= bel;
          ya <= !lt;
        end else begin
          xb <= bel;
          xa <= !lt;
        end
        if (bel) p <= IDX_W'(1);
        else if (!lt) p <= n_m1;
        else p <= hc;
      end
      ST_AX_MID: begin
        if (!lt && gt && (p < n_m1)) p <= p + 1'b1;
      end
      ST_AX_DOWN: begin
        if (lt) p <= p - 1'b1;
      end
      ST_AX_UP: begin
        if (gt && (p < n_m1)) p <= p + 1'b1;
      end
      ST_AX_HI: begin
        if (ax) begin
          y0v      <= t_rd;
          y_hi_idx <= p;
        end else begin
          x0v      <= t_rd;
          x_hi_idx <= p;
        end
      end
      ST_AX_END: begin
        if (ax) y1v <= t_rd;
        else x1v <= t_rd;
        ax   <= 1'b1;
        gcnt <= '0;
      end
      ST_GRID: begin
        gcnt <= gcnt + 1'b1;
        if (gcnt != '0) begin
          g[0] <= g[1];
          g[1] <= g[2];
          g[2] <= g[3];
          g[3] <= $signed(grid_rd);
        end
        if (gcnt == '0) begin
          wx0 <= W_W'(x1v) - W_W'(cmd_q.coord_x);
          wx1 <= W_W'(cmd_q.coord_x) - W_W'(x0v);
          wy0 <= W_W'(y1v) - W_W'(cmd_q.coord_y);
          wy1 <= W_W'(cmd_q.coord_y) - W_W'(y0v);
          dx  <= W_W'(x1v) - W_W'(x0v);
          dy  <= W_W'(y1v) - W_W'(y0v);
        end
        acc   <= '0;
        mstep <= '0;
      end
      ST_MAC: begin
        mstep <= mstep + 1'b1;
        prod  <= mul_a * mul_b;
        case (mstep)
          4'd1, 4'd7: rs <= prod[RS_W-1:0];
          4'd2, 4'd8: rs <= rs + prod[RS_W-1:0];
          4'd4, 4'd10: acc <= acc + ACC_W'(prod);
          4'd5, 4'd11: acc <= acc + $signed({prod, {VAL_W{1'b0}}});
          4'd13: begin
            aneg <= prod[PROD_W-1];
            nneg <= acc[ACC_W-1];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  bti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc_mag),
    .den   (prod_mag[AREA_W-1:0]),
    .done  (div_done),
    .quo   (quo)
  );

  // Result word, written once per query.
  always_ff @(posedge clk) begin
    if ((state == ST_GRID && gcnt == 3'd4 && ((dx == '0) || (dy == '0))) ||
        (state == ST_DIV && div_done)) begin
      rsp.x_below      <= xb;
      rsp.x_above      <= xa;
      rsp.y_below      <= yb;
      rsp.y_above      <= ya;
      rsp.table_status <= stat_q;
      if (state == ST_GRID) begin
        rsp.result_value <= '0;
        rsp.saturated    <= 1'b0;
      end else if (qneg) begin
        rsp.result_value <= big_neg ? $signed({1'b1, {(VAL_W-1){1'b0}}})
                                    : $signed(-quo[VAL_W-1:0]);
        rsp.saturated    <= big_neg;
      end else begin
        rsp.result_value <= big_pos ? $signed({1'b0, {(VAL_W-1){1'b1}}})
                                    : $signed(quo[VAL_W-1:0]);
        rsp.saturated    <= big_pos;
      end
    end
  end

endmodule

[hdl/bti_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on the first port, registered read on the second.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bti_div.sv]
// Restoring divider: one quotient bit per cycle for the unsigned numerator magnitude.
module bti_div
  import bti_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  num,
  input  logic [AREA_W-1:0] den,
  output logic              done,
  output logic [ACC_W-1:0]  quo
);

  logic [AREA_W-1:0] rem;
  logic [AREA_W-1:0] dvs;
  logic [QCNT_W-1:0] cnt;
  logic [AREA_W:0]   trial;
  logic              fits;

  // Shift the next numerator bit into the partial remainder and try the subtract.
  assign trial = {rem, quo[ACC_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= QCNT_W'(ACC_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == QCNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient bits replace the numerator bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (cnt != '0) begin
      rem <= fits ? AREA_W'(trial - {1'b0, dvs}) : trial[AREA_W-1:0];
      quo <= {quo[ACC_W-2:0], fits};
    end
  end

endmodule

[hdl/bti_checker.sv]
// Port-level checks for the table interpolator and the bind that attaches them.
module bti_checker
  import bti_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input in_word_t         cmd,
  input logic             busy,
  input out_word_t        rsp,
  input logic             rsp_strobe,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic             cfg_index,
  input logic [CNT_W-1:0] cfg_data
);

  // A result word only closes work that kept the block busy.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe |-> $past(busy))
    else $error("result word without a preceding busy query");

  // Two result words never come in adjacent cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe |=> !rsp_strobe)
    else $error("result words in adjacent cycles");

  // An accepted query always occupies the block.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.mode == MODE_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  // A clipped result sits on one of the two range limits.
  a_sat_limits: assert property (@(posedge clk) disable iff (rst)
    (rsp_strobe && rsp.saturated) |->
      (rsp.result_value == 32'sh7fffffff || rsp.result_value == 32'sh80000000))
    else $error("saturated result not at a range limit");

  // The status code never takes the unused value.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe |-> (rsp.table_status == STATUS_OK || rsp.table_status == STATUS_X_BAD ||
                    rsp.table_status == STATUS_Y_BAD))
    else $error("unused table status code");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (.*);
